>>> hdl/rob_pkg.sv
// Package for the in-order reorder buffer: sizes, command and result codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package rob_pkg;

  // Buffer geometry.
  localparam int Depth  = 16;
  localparam int MaxOut = 16;
  localparam int PtrW   = $clog2(Depth);
  localparam int OccW   = $clog2(Depth + 1);
  localparam int CntW   = (MaxOut > 1) ? $clog2(MaxOut) : 1;

  // Fixed field widths.
  localparam int CmdW  = 2;
  localparam int IdW   = 16;
  localparam int SlotW = 4;
  localparam int TagW  = 32;
  localparam int KindW = 3;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [OccW-1:0] occ_t;
  typedef logic [CntW-1:0] cnt_t;

  // Input command codes.
  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_RETIRE   = 2'd2
  } cmd_e;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_ALLOC    = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_CMPL_ACK = 3'd2,
    KIND_RETIRED  = 3'd3,
    KIND_NONE_RET = 3'd4
  } kind_e;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ALLOC,
    OP_COMPLETE,
    OP_RETIRE,
    OP_NONE_RET
  } op_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_RETIRE
  } state_e;

  // Command from controller to datapath.
  typedef struct packed {
    op_e  op;
    logic last;
  } ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic head_ready;  // head entry exists and is complete
    logic next_ready;  // entry after the head exists and is complete
  } stat_t;

  // Advance a circular pointer by one slot.
  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

>>> hdl/rob_ctrl.sv
// Controller for the reorder buffer: accepts commands and sequences retire bursts.
// Depends on rob_pkg.
module rob_ctrl
  import rob_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CmdW-1:0]  cmd_i,
  input  stat_t            stat_i,
  output ctrl_t            ctrl_o,
  output logic             busy_o
);

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;

  // State and burst counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl_o.op   = OP_IDLE;
    ctrl_o.last = 1'b1;
    busy_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_e'(cmd_i))
            CMD_ALLOC:    ctrl_o.op = OP_ALLOC;
            CMD_COMPLETE: ctrl_o.op = OP_COMPLETE;
            CMD_RETIRE: begin
              state_d = ST_RETIRE;
              cnt_d   = '0;
            end
            default: ctrl_o.op = OP_IDLE;
          endcase
        end
      end
      ST_RETIRE: begin
        busy_o = 1'b1;
        if (!stat_i.head_ready) begin
          // Nothing at the head is complete: a single empty answer.
          ctrl_o.op = OP_NONE_RET;
          state_d   = ST_IDLE;
        end else begin
          ctrl_o.op   = OP_RETIRE;
          ctrl_o.last = !(stat_i.next_ready && (cnt_q != cnt_t'(MaxOut - 1)));
          cnt_d       = cnt_q + cnt_t'(1);
          if (ctrl_o.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/rob_dpath.sv
// Datapath for the reorder buffer: entry storage, pointers, tag counter and the
// result register. Depends on rob_pkg.
module rob_dpath
  import rob_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  logic [IdW-1:0]    instr_id_i,
  input  logic [SlotW-1:0]  slot_i,
  output stat_t             stat_o,
  output logic              strobe_o,
  output logic [KindW-1:0]  kind_o,
  output logic [SlotW-1:0]  slot_out_o,
  output logic [TagW-1:0]   tag_out_o,
  output logic [IdW-1:0]    id_out_o,
  output logic              last_o
);

  // Entry payload storage.
  logic [IdW-1:0]  id_mem_q  [Depth];
  logic [TagW-1:0] tag_mem_q [Depth];

  logic [Depth-1:0] valid_q, valid_d;
  logic [Depth-1:0] done_q, done_d;
  ptr_t             head_q, head_d;
  ptr_t             tail_q, tail_d;
  occ_t             occ_q, occ_d;
  logic [TagW-1:0]  tag_q, tag_d;

  logic             full;
  ptr_t             alloc_slot;
  ptr_t             head_nxt;
  logic             slot_ok;
  ptr_t             slot_idx;

  // Result register.
  logic             strobe_q, strobe_d;
  kind_e            kind_q, kind_d;
  logic [SlotW-1:0] slot_out_q, slot_out_d;
  logic [TagW-1:0]  tag_out_q;
  logic [IdW-1:0]   id_out_q;
  logic             last_q;

  assign full       = (occ_q == occ_t'(Depth));
  assign alloc_slot = (occ_q == '0) ? '0 : tail_q;
  assign head_nxt   = next_ptr(head_q);
  assign slot_ok    = (int'(slot_i) < Depth);
  assign slot_idx   = ptr_t'(slot_i);

  // Retire status toward the controller.
  assign stat_o.head_ready = (occ_q != '0) && done_q[head_q];
  assign stat_o.next_ready = (occ_q > occ_t'(1)) && done_q[head_nxt];

  // Next state of the control registers and the result code.
  always_comb begin
    valid_d    = valid_q;
    done_d     = done_q;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    tag_d      = tag_q;
    strobe_d   = 1'b1;
    kind_d     = KIND_NONE_RET;
    slot_out_d = '0;
    case (ctrl_i.op)
      OP_ALLOC: begin
        if (full) begin
          kind_d = KIND_FULL;
        end else begin
          kind_d              = KIND_ALLOC;
          slot_out_d          = SlotW'(alloc_slot);
          valid_d[alloc_slot] = 1'b1;
          done_d[alloc_slot]  = 1'b0;
          if (occ_q == '0) begin
            head_d = '0;
          end
          tail_d = next_ptr(alloc_slot);
          occ_d  = occ_q + occ_t'(1);
          tag_d  = tag_q + TagW'(1);
        end
      end
      OP_COMPLETE: begin
        kind_d     = KIND_CMPL_ACK;
        slot_out_d = slot_i;
        if (slot_ok && valid_q[slot_idx]) begin
          done_d[slot_idx] = 1'b1;
        end
      end
      OP_RETIRE: begin
        kind_d          = KIND_RETIRED;
        slot_out_d      = SlotW'(head_q);
        valid_d[head_q] = 1'b0;
        done_d[head_q]  = 1'b0;
        occ_d           = occ_q - occ_t'(1);
        head_d          = head_nxt;
      end
      OP_NONE_RET: kind_d = KIND_NONE_RET;
      default:     strobe_d = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      done_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      tag_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      done_q   <= done_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      tag_q    <= tag_d;
      strobe_q <= strobe_d;
    end
  end

  // Entry storage write on allocation.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_ALLOC && !full) begin
      id_mem_q[alloc_slot]  <= instr_id_i;
      tag_mem_q[alloc_slot] <= tag_q;
    end
  end

  // Result payload, including the registered read of the head entry.
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    slot_out_q <= slot_out_d;
    last_q     <= ctrl_i.last;
    if (ctrl_i.op == OP_ALLOC && !full) begin
      tag_out_q <= tag_q;
      id_out_q  <= '0;
    end else if (ctrl_i.op == OP_RETIRE) begin
      tag_out_q <= tag_mem_q[head_q];
      id_out_q  <= id_mem_q[head_q];
    end else begin
      tag_out_q <= '0;
      id_out_q  <= '0;
    end
  end

  assign strobe_o   = strobe_q;
  assign kind_o     = kind_q;
  assign slot_out_o = slot_out_q;
  assign tag_out_o  = tag_out_q;
  assign id_out_o   = id_out_q;
  assign last_o     = last_q;

endmodule

>>> hdl/reorder_buffer_in_order_retire_core.sv
// In-order reorder buffer of 16 entries. An allocate or complete transaction is
// taken in any cycle in which busy_o is low, and its single result appears with
// strobe_o in the next cycle, so these commands run at one per cycle. A retire
// transaction moves the controller to its retire state, which raises busy_o and
// retires complete entries from the head (at most 16; a single empty answer when
// nothing retires) while the head pointer steps one entry per cycle; its results
// pass through the result register, one per cycle, with last_o on the final one.
// Results cannot be held off and must be taken in the cycle they are strobed.
// Depends on rob_pkg, rob_ctrl and rob_dpath.
module reorder_buffer_in_order_retire_core
  import rob_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [IdW-1:0]    instr_id_i,
  input  logic [SlotW-1:0]  slot_i,
  output logic              strobe_o,
  output logic [KindW-1:0]  kind_o,
  output logic [SlotW-1:0]  slot_out_o,
  output logic [TagW-1:0]   tag_out_o,
  output logic [IdW-1:0]    id_out_o,
  output logic              last_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Command sequencing.
  rob_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  // Entry storage and result register.
  rob_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .instr_id_i(instr_id_i),
    .slot_i    (slot_i),
    .stat_o    (stat),
    .strobe_o  (strobe_o),
    .kind_o    (kind_o),
    .slot_out_o(slot_out_o),
    .tag_out_o (tag_out_o),
    .id_out_o  (id_out_o),
    .last_o    (last_o)
  );

`ifndef NO_ASSERTIONS
  // A burst result that is not the last one is followed directly by another.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("retire burst broke off before its last result");

  // Only retired entries can be followed by more results of the same transaction.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o != KIND_RETIRED) |-> last_o)
    else $error("single-result transaction without last");

  // An accepted allocate answers in the next cycle with a final result.
  a_alloc_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i == CMD_ALLOC) |=>
      strobe_o && last_o && ((kind_o == KIND_ALLOC) || (kind_o == KIND_FULL)))
    else $error("allocate transaction not answered in the next cycle");

  // While a burst is in progress, every result is a retired or an empty retire result.
  a_busy_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(busy_o) && strobe_o |->
      (kind_o == KIND_RETIRED) || (kind_o == KIND_NONE_RET))
    else $error("unexpected result kind during a retire burst");
`endif

endmodule
